[rtl/sklc_pkg.sv]
`timescale 1ns / 1ps

package sklc_pkg;

    // Q format of every value
    localparam int FRAC_BITS = 16;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int RATIO_W    = 17;
    localparam int PERIOD_W   = 16;

    typedef logic signed [DATA_W-1:0] data_t;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_RATIO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd3;

    localparam logic [DATA_W-1:0]   PNOISE_RST = 32'd655;
    localparam logic [DATA_W-1:0]   MNOISE_RST = 32'd32768;
    localparam logic [RATIO_W-1:0]  RATIO_RST  = 17'd26214;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd328;
    localparam logic [DATA_W-1:0]   COV_RST    = DATA_W'(1) << FRAC_BITS;

    // gain K lies in [0, 1.0]
    localparam int              K_W     = FRAC_BITS + 1;
    localparam logic [K_W-1:0]  K_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam int              K_STEPS = K_W;

    // divide by ten: |7*sv + 3*diff| stays below 2^35
    // q = 0.8n by a shift-add series, q >> 3, then one correction on the remainder
    localparam int                       D10_W       = DATA_W + 4;
    localparam int                       D10_STEPS   = 4;
    localparam int                       D10_SH_W    = 6;
    localparam logic [D10_SH_W-1:0]      D10_SHIFT0  = 6'd4;
    localparam int                       D10_POST_SH = 3;
    localparam int                       D10_REM_W   = 5;
    localparam logic [D10_REM_W-1:0]     D10_DIVISOR = 5'd10;

    // velocity divider, two quotient bits per cycle
    localparam int VEL_RADIX_W = 2;
    localparam int VEL_STEPS   = DATA_W / VEL_RADIX_W;

    localparam int STEP_MAX = (K_STEPS > VEL_STEPS) ? K_STEPS : VEL_STEPS;
    localparam int CNT_W    = $clog2(STEP_MAX);

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic load_in;
        logic kinit;
        logic kstep;
        logic mul;
        logic upd;
        logic svsum;
        logic d10init;
        logic d10step;
        logic d10fix;
        logic svfin;
        logic vinit;
        logic vstep;
        logic out_load;
    } sklc_cmd_t;

    typedef struct packed {
        logic out_free;
    } sklc_status_t;

    function automatic data_t sat_data(input logic signed [63:0] v);
        data_t r;
        if (v > 64'(DATA_MAX))
            r = DATA_MAX;
        else if (v < 64'(DATA_MIN))
            r = DATA_MIN;
        else
            r = DATA_W'(v);
        return r;
    endfunction

endpackage

[rtl/sklc_if.sv]
`timescale 1ns / 1ps

interface sklc_in_if import sklc_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sklc_out_if import sklc_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t compensated;
    data_t filtered;
    data_t velocity;

    modport source (output valid, output compensated, output filtered, output velocity,
                    input ready);
    modport sink   (input valid, input compensated, input filtered, input velocity,
                    output ready);
endinterface

[rtl/sklc_ctrl.sv]
`timescale 1ns / 1ps

module sklc_ctrl import sklc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sklc_status_t status,
    output sklc_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_PREP    = 4'd1;
    localparam logic [3:0] ST_KDIV    = 4'd2;
    localparam logic [3:0] ST_MUL     = 4'd3;
    localparam logic [3:0] ST_UPD     = 4'd4;
    localparam logic [3:0] ST_SVSUM   = 4'd5;
    localparam logic [3:0] ST_D10INIT = 4'd6;
    localparam logic [3:0] ST_D10     = 4'd7;
    localparam logic [3:0] ST_SVFIN   = 4'd8;
    localparam logic [3:0] ST_VINIT   = 4'd9;
    localparam logic [3:0] ST_VDIV    = 4'd10;
    localparam logic [3:0] ST_OUT     = 4'd11;
    localparam logic [3:0] ST_D10FIX  = 4'd12;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.kinit  = 1'b1;
                cnt_next   = CNT_W'(K_STEPS - 1);
                state_next = ST_KDIV;
            end
            ST_KDIV:
            begin
                cmd.kstep = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_SVSUM;
            end
            ST_SVSUM:
            begin
                cmd.svsum  = 1'b1;
                state_next = ST_D10INIT;
            end
            ST_D10INIT:
            begin
                cmd.d10init = 1'b1;
                cnt_next    = CNT_W'(D10_STEPS - 1);
                state_next  = ST_D10;
            end
            ST_D10:
            begin
                cmd.d10step = 1'b1;
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_D10FIX;
            end
            ST_D10FIX:
            begin
                cmd.d10fix = 1'b1;
                state_next = ST_SVFIN;
            end
            ST_SVFIN:
            begin
                cmd.svfin  = 1'b1;
                state_next = ST_VINIT;
            end
            ST_VINIT:
            begin
                cmd.vinit  = 1'b1;
                cnt_next   = CNT_W'(VEL_STEPS - 1);
                state_next = ST_VDIV;
            end
            ST_VDIV:
            begin
                cmd.vstep = 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold here while the previous result still sits unread
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register still occupied");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_PREP))
        else $error("accepted sample did not start the update sequence");

    a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !status.out_free) |=> (state_reg == ST_OUT))
        else $error("left output state while result register busy");

endmodule

[rtl/sklc_dp.sv]
`timescale 1ns / 1ps

module sklc_dp import sklc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  data_t                 sample,
    input  sklc_cmd_t             cmd,
    output sklc_status_t          status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output data_t                 out_compensated,
    output data_t                 out_filtered,
    output data_t                 out_velocity
);

    localparam int PF_W = K_W + DATA_W + 2;   // (K+sign) * (z - x)
    localparam int PC_W = K_W + DATA_W;       // (1 - K) * Ppred
    localparam int PV_W = DATA_W + RATIO_W + 1;

    // configuration
    logic [DATA_W-1:0]   pnoise_reg;
    logic [DATA_W-1:0]   mnoise_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [PERIOD_W-1:0] period_reg;

    // filter state
    data_t               est_reg;
    logic [DATA_W-1:0]   cov_reg, cov_next;
    data_t               sv_reg, sv_next;

    // per-item working registers
    data_t                     z_reg;
    logic [DATA_W-1:0]         ppred_reg, ppred_next;
    logic [DATA_W:0]           den_reg, den_next;
    logic signed [DATA_W:0]    zx_reg, zx_next;
    logic [DATA_W+1:0]         krem_reg, krem_next;
    logic [K_W-1:0]            kq_reg, kq_next;
    logic signed [PF_W-1:0]    prodf_reg, prodf_next;
    logic [PC_W-1:0]           prodc_reg, prodc_next;
    data_t                     f_reg, f_next;
    logic signed [D10_W-1:0]   num_reg, num_next;
    logic                      dneg_reg;
    logic [D10_W-1:0]          dmag_reg, dmag_next;
    logic [D10_W-1:0]          dq_reg, dq_init, dq_next;
    logic [D10_SH_W-1:0]       damt_reg;
    logic [D10_W-1:0]          dquo_reg;
    logic [D10_REM_W-1:0]      drem_reg;
    logic signed [PV_W-1:0]    vprod_reg, vprod_next;
    logic                      vneg_reg, vzero_reg, vovf_reg, vovf_next;
    logic [DATA_W-1:0]         vsh_reg, vsh_next;
    logic [PERIOD_W-1:0]       vrem_reg, vrem_next;

    // output register
    logic  out_valid_reg;
    data_t out_comp_reg, out_filt_reg, out_vel_reg;
    data_t comp_next, vel_next;

    // combinational helpers
    logic [DATA_W:0]             psum;
    logic                        kge;
    logic [DATA_W+1:0]           kdiff;
    logic [K_W-1:0]              k_eff;
    logic [K_W-1:0]              kc;
    logic signed [K_W:0]         ks;
    logic signed [PF_W-1:0]      f_wide;
    logic signed [D10_W-1:0]     sv_ext, d_ext;
    logic [D10_W-1:0]            dqf, dr_w;
    logic                        dcarry, dround;
    logic [1:0]                  dinc;
    logic [D10_W:0]              qm;
    logic signed [D10_W+1:0]     sv_wide;
    logic [DATA_W-1:0]           vmag, vhigh;
    logic signed [63:0]          comp_wide, vel_wide;
    logic [PERIOD_W:0]           vt;
    logic [PERIOD_W-1:0]         vr;
    logic [DATA_W-1:0]           vsh_w;

    always_comb
    begin
        // predicted covariance, saturated
        psum       = {1'b0, cov_reg} + {1'b0, pnoise_reg};
        ppred_next = psum[DATA_W] ? '1 : psum[DATA_W-1:0];

        den_next = {1'b0, ppred_reg} + {1'b0, mnoise_reg};
        zx_next  = $signed({z_reg[DATA_W-1], z_reg}) - $signed({est_reg[DATA_W-1], est_reg});

        // gain divider: one quotient bit per cycle
        kge       = (krem_reg >= {1'b0, den_reg});
        kdiff     = kge ? (krem_reg - {1'b0, den_reg}) : krem_reg;
        krem_next = {kdiff[DATA_W:0], 1'b0};
        kq_next   = {kq_reg[K_W-2:0], kge};

        k_eff      = (den_reg == '0) ? K_ONE : kq_reg;
        ks         = $signed({1'b0, k_eff});
        kc         = K_ONE - k_eff;
        prodf_next = ks * zx_reg;
        prodc_next = kc * ppred_reg;

        f_wide   = PF_W'(est_reg) + (prodf_reg >>> FRAC_BITS);
        f_next   = f_wide[DATA_W-1:0];
        cov_next = prodc_reg[FRAC_BITS +: DATA_W];

        // 7 * sv + 3 * (filtered - x)
        sv_ext   = D10_W'(sv_reg);
        d_ext    = D10_W'(f_reg) - D10_W'(est_reg);
        num_next = (sv_ext <<< 3) - sv_ext + (d_ext <<< 1) + d_ext;

        // divide the magnitude by ten: q ~ 0.8n, refined by q += q >> 4, 8, 16, 32
        dmag_next = num_reg[D10_W-1] ? D10_W'(-num_reg) : D10_W'(num_reg);
        dq_init   = (dmag_next >> 1) + (dmag_next >> 2);
        dq_next   = dq_reg + (dq_reg >> damt_reg);

        // q >> 3 is the quotient or one less; remainder then lies in [0, 19]
        dqf  = dq_reg >> D10_POST_SH;
        dr_w = dmag_reg - ((dqf << 3) + (dqf << 1));

        // correct the quotient, and for negative values round the magnitude
        // up when the true remainder is nonzero (floor)
        dcarry = (drem_reg >= D10_DIVISOR);
        dround = dneg_reg && (drem_reg != '0) && (drem_reg != D10_DIVISOR);
        dinc   = {dcarry & dround, dcarry ^ dround};
        qm      = {1'b0, dquo_reg} + (D10_W+1)'(dinc);
        sv_wide = dneg_reg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        sv_next = sat_data(64'(sv_wide));

        // velocity divider setup; quotient >= 2^DATA_W shows up in the top part
        vmag       = sv_reg[DATA_W-1] ? DATA_W'(-sv_reg) : sv_reg;
        vhigh      = vmag >> (DATA_W - FRAC_BITS);
        vovf_next  = (vhigh >= DATA_W'(period_reg));
        vprod_next = sv_reg * $signed({1'b0, ratio_reg});

        vr    = vrem_reg;
        vsh_w = vsh_reg;
        for (int i = 0; i < VEL_RADIX_W; i++)
        begin
            vt    = {vr, vsh_w[DATA_W-1]};
            vsh_w = {vsh_w[DATA_W-2:0], 1'b0};
            if (vt >= {1'b0, period_reg})
            begin
                vt       = vt - {1'b0, period_reg};
                vsh_w[0] = 1'b1;
            end
            vr = vt[PERIOD_W-1:0];
        end
        vsh_next  = cmd.vinit ? (vmag << FRAC_BITS) : vsh_w;
        vrem_next = cmd.vinit ? vhigh[PERIOD_W-1:0] : vr;

        comp_wide = 64'(f_reg) + 64'(vprod_reg >>> FRAC_BITS);
        comp_next = sat_data(comp_wide);

        vel_wide = vneg_reg ? -$signed({32'b0, vsh_reg}) : $signed({32'b0, vsh_reg});
        if (vzero_reg)
            vel_next = '0;
        else if (vovf_reg)
            vel_next = vneg_reg ? DATA_MIN : DATA_MAX;
        else
            vel_next = sat_data(vel_wide);
    end

    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_compensated = out_comp_reg;
    assign out_filtered    = out_filt_reg;
    assign out_velocity    = out_vel_reg;

    // configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pnoise_reg <= PNOISE_RST;
            mnoise_reg <= MNOISE_RST;
            ratio_reg  <= RATIO_RST;
            period_reg <= PERIOD_RST;
            est_reg    <= '0;
            cov_reg    <= COV_RST;
            sv_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE: pnoise_reg <= cfg_data[DATA_W-1:0];
                    CFG_MEASURE_NOISE: mnoise_reg <= cfg_data[DATA_W-1:0];
                    CFG_COMP_RATIO:    ratio_reg  <= cfg_data[RATIO_W-1:0];
                    CFG_SAMPLE_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    default:           pnoise_reg <= pnoise_reg;
                endcase
            end
            if (cmd.upd)
                cov_reg <= cov_next;
            if (cmd.svsum)
                est_reg <= f_reg;
            if (cmd.svfin)
                sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            z_reg     <= sample;
            ppred_reg <= ppred_next;
        end
        if (cmd.kinit)
        begin
            den_reg  <= den_next;
            zx_reg   <= zx_next;
            krem_reg <= {2'b00, ppred_reg};
            kq_reg   <= '0;
        end
        if (cmd.kstep)
        begin
            krem_reg <= krem_next;
            kq_reg   <= kq_next;
        end
        if (cmd.mul)
        begin
            prodf_reg <= prodf_next;
            prodc_reg <= prodc_next;
        end
        if (cmd.upd)
            f_reg <= f_next;
        if (cmd.svsum)
            num_reg <= num_next;
        if (cmd.d10init)
        begin
            dneg_reg <= num_reg[D10_W-1];
            dmag_reg <= dmag_next;
            dq_reg   <= dq_init;
            damt_reg <= D10_SHIFT0;
        end
        if (cmd.d10step)
        begin
            dq_reg   <= dq_next;
            damt_reg <= damt_reg << 1;
        end
        if (cmd.d10fix)
        begin
            dquo_reg <= dqf;
            drem_reg <= dr_w[D10_REM_W-1:0];
        end
        if (cmd.vinit)
        begin
            vprod_reg <= vprod_next;
            vneg_reg  <= sv_reg[DATA_W-1];
            vzero_reg <= (sv_reg == '0);
            vovf_reg  <= vovf_next;
        end
        if (cmd.vinit || cmd.vstep)
        begin
            vsh_reg  <= vsh_next;
            vrem_reg <= vrem_next;
        end
        if (cmd.out_load)
        begin
            out_comp_reg <= comp_next;
            out_filt_reg <= f_reg;
            out_vel_reg  <= vel_next;
        end
    end

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> (k_eff <= K_ONE))
        else $error("gain quotient above 1.0");

    a_estimate_between: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> ((f_reg >= $past(z_reg) && f_reg <= $past(est_reg)) ||
                     (f_reg <= $past(z_reg) && f_reg >= $past(est_reg))))
        else $error("new estimate outside sample and old estimate");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

[rtl/scalar_kalman_lag_comp_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Payload                                Transaction when
// --------  ---------  -------------------------------------  ----------------------
// in_ch     in         sample (s32 Q16.16)                    valid && ready
// out_ch    out        compensated, filtered, velocity (s32)  valid && ready
// cfg       in         cfg_index (2b), cfg_data (32b)         cfg_we
//
// A new sample is accepted only after the previous one is fully processed: the gain
// divider resolves one quotient bit a cycle (FRAC_BITS + 1 bits), divide by
// ten runs a four-step shift-add series, the velocity divider two bits a
// cycle, besides the steps for acceptance, setup, multiply, update, quotient
// correction and output load. Reset restores registers and filter state at
// once, with no clearing pass. A result waiting in the output register does
// not block the next sample; only when the next result is ready while the
// previous one is still unread does the block hold until out_ch.ready.

module scalar_kalman_lag_comp_core import sklc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sklc_in_if.sink               in_ch,
    sklc_out_if.source            out_ch
);

    sklc_cmd_t    cmd;
    sklc_status_t status;
    logic         in_ready;

    assign in_ch.ready = in_ready;

    sklc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sklc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample          (in_ch.sample),
        .cmd             (cmd),
        .status          (status),
        .out_ready       (out_ch.ready),
        .out_valid       (out_ch.valid),
        .out_compensated (out_ch.compensated),
        .out_filtered    (out_ch.filtered),
        .out_velocity    (out_ch.velocity)
    );

endmodule

[test/tb_scalar_kalman_lag_comp_core.sv]
`timescale 1ns / 1ps

module tb_scalar_kalman_lag_comp_core;
    import sklc_pkg::*;

    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     DRAIN_CYCLES = 64;
    localparam int     LONG_HOLD    = 3000;
    localparam longint Q_ONE        = longint'(1) << FRAC_BITS;
    localparam longint U32_MAX      = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        data_t compensated;
        data_t filtered;
        data_t velocity;
    } kf_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sklc_in_if  in_ch ();
    sklc_out_if out_ch ();

    scalar_kalman_lag_comp_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // filter state and register copies
    longint q_val      = longint'(PNOISE_RST);
    longint r_val      = longint'(MNOISE_RST);
    longint ratio_val  = longint'(RATIO_RST);
    longint period_val = longint'(PERIOD_RST);
    longint est_val    = 0;
    longint cov_val    = longint'(COV_RST);
    longint svel_val   = 0;

    // synthetic target path for well-formed sample streams
    longint traj_pos = 0;
    longint traj_vel = 0;

    data_t      sample_queue[$];
    kf_result_t predicted_outputs[$];

    bit in_taken  = 0;
    bit in_flight = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int cycle_cnt     = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp_s32(input longint v);
        longint r;
        if (v > longint'(DATA_MAX))
            r = longint'(DATA_MAX);
        else if (v < longint'(DATA_MIN))
            r = longint'(DATA_MIN);
        else
            r = v;
        return r;
    endfunction

    function automatic kf_result_t kalman_update(input data_t z_in);
        longint     z;
        longint     x;
        longint     ppred;
        longint     den;
        longint     k;
        longint     filt;
        longint     sv_sum;
        longint     sv_new;
        longint     comp;
        longint     vel;
        kf_result_t r;
        z = z_in;
        x = est_val;
        ppred = cov_val + q_val;
        if (ppred > U32_MAX)
            ppred = U32_MAX;
        den = ppred + r_val;
        k = (den == 0) ? Q_ONE : (ppred << FRAC_BITS) / den;
        if (k > Q_ONE)
            k = Q_ONE;
        filt = clamp_s32(x + ((k * (z - x)) >>> FRAC_BITS));
        cov_val = (((Q_ONE - k) * ppred) >> FRAC_BITS) & U32_MAX;
        // floor division by ten
        sv_sum = 7 * svel_val + 3 * (filt - x);
        sv_new = sv_sum / 10;
        if ((sv_sum % 10) != 0 && sv_sum < 0)
            sv_new = sv_new - 1;
        svel_val = clamp_s32(sv_new);
        est_val = filt;
        comp = clamp_s32(filt + ((svel_val * ratio_val) >>> FRAC_BITS));
        if (period_val == 0)
        begin
            if (svel_val > 0)
                vel = longint'(DATA_MAX);
            else if (svel_val < 0)
                vel = longint'(DATA_MIN);
            else
                vel = 0;
        end
        else
        begin
            vel = clamp_s32((svel_val * Q_ONE) / period_val);
        end
        r.compensated = data_t'(comp);
        r.filtered    = data_t'(filt);
        r.velocity    = data_t'(vel);
        return r;
    endfunction

    function automatic data_t gen_sample();
        int unsigned pick;
        longint      v;
        pick = $urandom_range(99);
        if (pick < 72)
        begin
            if (pick < 2)
                traj_pos = longint'(data_t'($urandom()));
            if ($urandom_range(15) == 0)
                traj_vel = longint'($urandom_range(6553600)) - 3276800;
            traj_pos = traj_pos + traj_vel;
            if (traj_pos > longint'(DATA_MAX) || traj_pos < longint'(DATA_MIN))
            begin
                traj_pos = clamp_s32(traj_pos);
                traj_vel = -traj_vel;
            end
            v = traj_pos + longint'($urandom_range(131072)) - 65536;
        end
        else if (pick < 90)
        begin
            v = longint'(data_t'($urandom()));
        end
        else
        begin
            case ($urandom_range(4))
                0: v = longint'(DATA_MAX);
                1: v = longint'(DATA_MIN);
                2: v = 0;
                3: v = 1;
                default: v = -1;
            endcase
        end
        return data_t'(clamp_s32(v));
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (in_ch.valid && !in_taken)
        begin
            // hold the offered transaction until it is taken
        end
        else if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
        begin
            in_ch.valid  <= 1'b1;
            in_ch.sample <= sample_queue.pop_front();
            in_flight = 1'b1;
        end
        else
        begin
            in_ch.valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n || hold_left != 0)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // check results first, then record accepted samples
    always @(posedge clk)
    begin
        kf_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: comp %0d filt %0d vel %0d",
                             out_ch.compensated, out_ch.filtered, out_ch.velocity);
            end
            else
            begin
                want = predicted_outputs.pop_front();
                if (want.compensated !== out_ch.compensated ||
                    want.filtered !== out_ch.filtered ||
                    want.velocity !== out_ch.velocity)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d, got %0d %0d %0d",
                                 want.compensated, want.filtered, want.velocity,
                                 out_ch.compensated, out_ch.filtered, out_ch.velocity);
                end
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predicted_outputs.push_back(kalman_update(in_ch.sample));
            in_taken = 1'b1;
            in_flight = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_PROCESS_NOISE: q_val = longint'(data);
            CFG_MEASURE_NOISE: r_val = longint'(data);
            CFG_COMP_RATIO:    ratio_val = longint'(data[RATIO_W-1:0]);
            CFG_SAMPLE_PERIOD: period_val = longint'(data[PERIOD_W-1:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] q, input logic [31:0] r,
                              input logic [31:0] ratio, input logic [31:0] period);
        write_reg(CFG_PROCESS_NOISE, q);
        write_reg(CFG_MEASURE_NOISE, r);
        write_reg(CFG_COMP_RATIO, ratio);
        write_reg(CFG_SAMPLE_PERIOD, period);
    endtask

    task automatic wait_drain();
        while (sample_queue.size() != 0 || in_flight || predicted_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int n, input int s_pct, input int r_pct, input bit long_hold);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++)
            sample_queue.push_back(gen_sample());
        if (long_hold)
            hold_left = LONG_HOLD;
        wait_drain();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero noise: unit gain, then zero gain denominator; zero period
        set_config(32'd0, 32'd0, 32'h1FFFF, 32'd0);
        sample_queue.push_back(data_t'(0));
        sample_queue.push_back(DATA_MAX);
        sample_queue.push_back(DATA_MIN);
        sample_queue.push_back(DATA_MIN);
        sample_queue.push_back(DATA_MAX);
        sample_queue.push_back(data_t'(0));
        wait_drain();

        set_config(PNOISE_RST, MNOISE_RST, 32'(RATIO_RST), 32'(PERIOD_RST));
        sample_queue.push_back(data_t'(0));
        sample_queue.push_back(DATA_MAX);
        sample_queue.push_back(DATA_MIN);
        sample_queue.push_back(DATA_MAX);
        sample_queue.push_back(data_t'(1));
        sample_queue.push_back(data_t'(-1));
        sample_queue.push_back(data_t'(100 * 65536));
        sample_queue.push_back(data_t'(100 * 65536));
        sample_queue.push_back(data_t'(-100 * 65536));
        sample_queue.push_back(data_t'(32'h5555_5555));
        sample_queue.push_back(data_t'(32'hAAAA_AAAA));
        wait_drain();

        set_config(32'hFFFF_FFFF, 32'd1, 32'd65536, 32'd1);
        sample_queue.push_back(DATA_MAX);
        sample_queue.push_back(DATA_MIN);
        sample_queue.push_back(data_t'(12345));
        sample_queue.push_back(DATA_MAX);
        wait_drain();

        run_phase(300, 0, 0, 1'b0);

        set_config(32'd0, 32'd1, 32'd65536, 32'd1);
        run_phase(300, 54, 0, 1'b0);

        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1FFFF, 32'hFFFF);
        run_phase(300, 0, 54, 1'b0);

        set_config($urandom_range(262144), $urandom(), $urandom_range(65536),
                   $urandom_range(65535, 1));
        run_phase(300, 22, 22, 1'b1);

        set_config(32'd0, 32'd0, 32'd0, 32'd0);
        run_phase(200, 0, 0, 1'b0);

        for (int p = 0; p < 4; p++)
        begin
            set_config($urandom(), $urandom() | 32'd1, $urandom_range(131071),
                       $urandom_range(65535));
            case (p)
                0: run_phase(125, 0, 0, 1'b0);
                1: run_phase(125, 54, 0, 1'b0);
                2: run_phase(125, 0, 54, 1'b0);
                default: run_phase(125, 22, 22, 1'b0);
            endcase
        end

        if (mismatches == 0 && predicted_outputs.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
